FILE: rtl/core/hfa_pkg.sv
package hfa_pkg;

    // Default sizing of the hole table.
    localparam int DEF_MAX_HOLES = 16;
    localparam int DEF_SIZE_BITS = 16;

    // Fixed widths of the word fields and registers.
    localparam int FIT_MODE_W   = 2;
    localparam int HOLE_COUNT_W = 5;
    localparam int HOLE_IDX_W   = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 5;

    // Placement policies.
    localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] FIT_NEXT  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd2;
    localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd3;

    // Input word kinds.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLE_COUNT = 1'b1;

    // Register reset values.
    localparam logic [FIT_MODE_W-1:0]   FIT_MODE_RESET   = FIT_FIRST;
    localparam logic [HOLE_COUNT_W-1:0] HOLE_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic                    req_type;
        logic [HOLE_IDX_W-1:0]   hole_index;
        logic [SIZE_FIELD_W-1:0] size_value;
        logic                    batch_end;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [HOLE_IDX_W-1:0]   hole_number;
        logic [SIZE_FIELD_W-1:0] left_in_hole;
    } out_item_t;

endpackage

FILE: rtl/core/hfa_cell.sv
module hfa_cell
    import hfa_pkg::*;
#(
    parameter int  MAX_HOLES = DEF_MAX_HOLES,
    parameter int  SIZE_BITS = DEF_SIZE_BITS,
    parameter int  CELL_IDX  = 0,
    parameter type ctl_t     = logic,
    parameter type probe_t   = logic
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  ctl_t   ctl,
    input  probe_t probe_in,
    output probe_t probe_out
);

    localparam int IDX_W = $clog2(MAX_HOLES);
    localparam int CNT_W = $clog2(MAX_HOLES + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] loaded_reg, loaded_next;
    logic [SIZE_BITS-1:0] free_reg, free_next;
    probe_t               probe_reg, probe_next;

    logic load_hit;
    logic sub_hit;
    logic fits;
    logic upper;
    logic take_upper;

    assign load_hit = ctl.load_en && (int'(ctl.load_idx) == CELL_IDX);
    assign sub_hit  = ctl.sub_en && (ctl.sub_idx == MY_IDX);

    always_comb begin
        loaded_next = load_hit ? ctl.load_val : loaded_reg;
        if (ctl.restore) begin
            free_next = loaded_reg;
        end else if (load_hit) begin
            free_next = ctl.load_val;
        end else if (sub_hit) begin
            free_next = free_reg - ctl.need;
        end else begin
            free_next = free_reg;
        end
    end

    // The search word collects two candidates: the upper one from holes at or
    // after the search start, and the lower one from holes before it. Only
    // the next-fit policy uses a nonzero start, so the lower candidate wraps
    // the search around the end of the table.
    always_comb begin
        fits  = probe_in.valid && (MY_POS < ctl.n) && (free_reg >= ctl.need);
        upper = MY_IDX >= ctl.start;
        take_upper = !probe_in.hi_found
                     || ((ctl.mode == FIT_BEST) && (free_reg < probe_in.hi_val))
                     || ((ctl.mode == FIT_WORST) && (free_reg > probe_in.hi_val));
        probe_next = probe_in;
        if (fits && upper) begin
            if (take_upper) begin
                probe_next.hi_found = 1'b1;
                probe_next.hi_idx   = MY_IDX;
                probe_next.hi_val   = free_reg;
            end
        end else if (fits && !probe_in.lo_found) begin
            probe_next.lo_found = 1'b1;
            probe_next.lo_idx   = MY_IDX;
            probe_next.lo_val   = free_reg;
        end
    end

    always_ff @(posedge aclk) begin
        loaded_reg <= loaded_next;
        free_reg   <= free_next;
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

FILE: rtl/core/hole_fit_allocator_core.sv
// Hole placement allocator. A load word writes one hole's size and restores its
// free size; its result goes through the result register to the output
// register. A request word sends a search word down a chain of one cell per
// hole, one cell per cycle; one word is worked on at a time. The chosen hole is
// charged and, on the last request of a batch, all free sizes and the next-fit
// start are restored in the same cycle the search ends. A finished result
// waits in the output register while the next word is accepted. Reading a
// hole never loaded since reset gives an undefined result.
module hole_fit_allocator_core
    import hfa_pkg::*;
#(
    parameter int MAX_HOLES = DEF_MAX_HOLES,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_HOLES);
    localparam int CNT_W = $clog2(MAX_HOLES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  need;
        logic [FIT_MODE_W-1:0] mode;
        logic [CNT_W-1:0]      n;
        logic [IDX_W-1:0]      start;
        logic                  load_en;
        logic [HOLE_IDX_W-1:0] load_idx;
        logic [SIZE_BITS-1:0]  load_val;
        logic                  sub_en;
        logic [IDX_W-1:0]      sub_idx;
        logic                  restore;
    } ctl_t;

    typedef struct packed {
        logic                 valid;
        logic                 hi_found;
        logic [IDX_W-1:0]     hi_idx;
        logic [SIZE_BITS-1:0] hi_val;
        logic                 lo_found;
        logic [IDX_W-1:0]     lo_idx;
        logic [SIZE_BITS-1:0] lo_val;
    } probe_t;

    logic [1:0]              state_reg, state_next;
    logic [FIT_MODE_W-1:0]   fit_mode_reg, fit_mode_next;
    logic [HOLE_COUNT_W-1:0] hole_count_reg, hole_count_next;
    logic [IDX_W-1:0]        next_start_reg, next_start_next;
    logic [SIZE_BITS-1:0]    need_reg, need_next;
    logic                    batch_reg, batch_next;
    logic                    inject_reg, inject_next;
    out_item_t               res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic                 accept;
    logic [CNT_W-1:0]     n_eff;
    logic [IDX_W-1:0]     start_eff;
    ctl_t                 ctl;
    probe_t               chain [MAX_HOLES+1];
    probe_t               tail;
    logic                 pick_found;
    logic [IDX_W-1:0]     pick_idx;
    logic [SIZE_BITS-1:0] pick_val;
    logic [SIZE_BITS-1:0] left;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (int'(hole_count_reg) > MAX_HOLES) begin
            n_eff = CNT_W'(MAX_HOLES);
        end else begin
            n_eff = CNT_W'(hole_count_reg);
        end
        if ((fit_mode_reg == FIT_NEXT) && (CNT_W'(next_start_reg) < n_eff)) begin
            start_eff = next_start_reg;
        end else begin
            start_eff = '0;
        end
    end

    // The upper candidate wins; the lower one only covers the wrapped part of
    // a next-fit search.
    assign tail       = chain[MAX_HOLES];
    assign pick_found = tail.hi_found || tail.lo_found;
    assign pick_idx   = tail.hi_found ? tail.hi_idx : tail.lo_idx;
    assign pick_val   = tail.hi_found ? tail.hi_val : tail.lo_val;
    assign left       = pick_val - need_reg;

    always_comb begin
        ctl.need     = need_reg;
        ctl.mode     = fit_mode_reg;
        ctl.n        = n_eff;
        ctl.start    = start_eff;
        ctl.load_en  = accept && (s_data.req_type == REQ_LOAD);
        ctl.load_idx = s_data.hole_index;
        ctl.load_val = SIZE_BITS'(s_data.size_value);
        ctl.sub_en   = (state_reg == ST_SCAN) && tail.valid && pick_found;
        ctl.sub_idx  = pick_idx;
        ctl.restore  = (state_reg == ST_SCAN) && tail.valid && batch_reg;
    end

    always_comb begin
        chain[0]          = '0;
        chain[0].valid    = inject_reg;
    end

    for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
        hfa_cell #(
            .MAX_HOLES(MAX_HOLES),
            .SIZE_BITS(SIZE_BITS),
            .CELL_IDX (i),
            .ctl_t    (ctl_t),
            .probe_t  (probe_t)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .probe_in (chain[i]),
            .probe_out(chain[i+1])
        );
    end

    always_comb begin
        state_next      = state_reg;
        fit_mode_next   = fit_mode_reg;
        hole_count_next = hole_count_reg;
        next_start_next = next_start_reg;
        need_next       = need_reg;
        batch_next      = batch_reg;
        inject_next     = 1'b0;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_FIT_MODE:   fit_mode_next = cfg_data[FIT_MODE_W-1:0];
                CFG_HOLE_COUNT: hole_count_next = cfg_data[HOLE_COUNT_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type == REQ_LOAD) begin
                        res_next.status       = STATUS_LOADED;
                        res_next.hole_number  = s_data.hole_index;
                        res_next.left_in_hole = '0;
                        state_next            = ST_DONE;
                    end else begin
                        need_next   = SIZE_BITS'(s_data.size_value);
                        batch_next  = s_data.batch_end;
                        inject_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tail.valid) begin
                    if (pick_found) begin
                        res_next.status       = STATUS_ALLOCATED;
                        res_next.hole_number  = HOLE_IDX_W'(pick_idx);
                        res_next.left_in_hole = SIZE_FIELD_W'(left);
                        next_start_next       = pick_idx;
                    end else begin
                        res_next.status       = STATUS_NO_FIT;
                        res_next.hole_number  = '0;
                        res_next.left_in_hole = '0;
                    end
                    if (batch_reg) begin
                        next_start_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        need_reg   <= need_next;
        batch_reg  <= batch_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fit_mode_reg   <= FIT_MODE_RESET;
            hole_count_reg <= HOLE_COUNT_RESET;
            next_start_reg <= '0;
            inject_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fit_mode_reg   <= fit_mode_next;
            hole_count_reg <= hole_count_next;
            next_start_reg <= next_start_next;
            inject_reg     <= inject_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule
